// ===== rtl/core/gced_pkg.sv =====
// Package for the global curvature energy block: payload structs, request
// codes, and widths shared by the front, back and top level.
// No dependencies.
package gced_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned CfgIdxW    = 1;

  typedef enum logic [1:0] {
    REQ_ACCUM  = 2'd0,
    REQ_EVAL   = 2'd1,
    REQ_COMMIT = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  localparam logic [CfgIdxW-1:0] CfgGain   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgTarget = 1'b1;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] delta_area;
    logic signed [31:0] delta_curvature;
    logic signed [31:0] principal_curv_one;
    logic signed [31:0] principal_curv_two;
  } in_word_t;

  typedef struct packed {
    logic signed [63:0] energy_change;
    logic signed [63:0] energy_now;
    logic               area_fault;
  } out_word_t;

  // Classified work word passed from front to back
  typedef struct packed {
    req_e               req;
    logic signed [31:0] delta_area;
    logic signed [31:0] delta_curvature;
    logic signed [32:0] curv_sum;
  } work_t;

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    logic signed [47:0] r;
    if (v > 50'sh0_7FFF_FFFF_FFFF) r = 48'sh7FFF_FFFF_FFFF;
    else if (v < -50'sh0_8000_0000_0000) r = 48'sh8000_0000_0000;
    else r = v[47:0];
    return r;
  endfunction

endpackage

// ===== rtl/core/global_curvature_energy_delta.sv =====
// Top level of the global curvature energy block: config registers, front
// queue and back sequencer. Results other than faults and the unused code
// wait on the one-bit-a-cycle 192-step divide. One word is in the back at a
// time and it takes the next only after the held result is popped; the
// front queue holds up to two more.
// Reset (asynchronous, active low) clears totals, energy and config to zero.
module global_curvature_energy_delta #(
  parameter int unsigned QueueDepth = gced_pkg::QueueDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  gced_pkg::in_word_t                in_word_i,
  output logic                              empty,
  input  logic                              pop,
  output gced_pkg::out_word_t               out_word_o,
  input  logic                              cfg_we_i,
  input  logic [gced_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [31:0]                       cfg_data_i
);
  logic [31:0]        gain_q;
  logic signed [31:0] target_q;
  logic               work_valid, work_take, res_valid;
  gced_pkg::work_t    work;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= '0;
      target_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gced_pkg::CfgGain:   gain_q   <= cfg_data_i;
        gced_pkg::CfgTarget: target_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gced_front #(.Depth(QueueDepth)) u_front (
    .clk_i, .rst_ni, .push, .full, .in_word_i,
    .work_valid_o(work_valid), .work_take_i(work_take), .work_o(work)
  );

  gced_back u_back (
    .clk_i, .rst_ni,
    .work_valid_i(work_valid), .work_take_o(work_take), .work_i(work),
    .gain_i(gain_q), .target_i(target_q),
    .res_valid_o(res_valid), .res_take_i(pop), .res_o(out_word_o)
  );

  assign empty = !res_valid;

  // Stored energy never goes negative
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !out_word_o.energy_now[63]) else $error("negative energy");
  // A fault result reports no energy change
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_word_o.area_fault) |-> (out_word_o.energy_change == '0))
    else $error("fault with nonzero change");
  // Pop of a held result clears it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !work_take) |=> empty || $changed(out_word_o))
    else $error("result not released");

endmodule

// ===== rtl/core/gced_front.sv =====
// Front stage: accepts input words, classifies the request and forms the
// curvature sum, then pushes a work word into a short queue.
// Depends on gced_pkg.
module gced_front #(
  parameter int unsigned Depth = gced_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  gced_pkg::in_word_t in_word_i,
  output logic               work_valid_o,
  input  logic               work_take_i,
  output gced_pkg::work_t    work_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  gced_pkg::work_t    mem_q [Depth];
  logic [PtrW-1:0]    wr_q, rd_q;
  logic [PtrW:0]      cnt_q;
  gced_pkg::work_t    cls;
  logic               do_push, do_pop;

  // Classify the incoming word
  always_comb begin
    cls.req             = gced_pkg::req_e'(in_word_i.req_type);
    cls.delta_area      = in_word_i.delta_area;
    cls.delta_curvature = in_word_i.delta_curvature;
    cls.curv_sum        = 33'(in_word_i.principal_curv_one) +
                          33'(in_word_i.principal_curv_two);
  end

  assign full         = (cnt_q == (PtrW+1)'(Depth));
  assign do_push      = push && !full;
  assign work_valid_o = (cnt_q != '0);
  assign do_pop       = work_take_i && work_valid_o;
  assign work_o       = mem_q[rd_q];

  // Store queue entries
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= cls;
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(Depth-1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PtrW'(Depth-1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
    end
  end

endmodule

// ===== rtl/core/gced_back.sv =====
// Back stage: sequencer that updates totals, forms (C - c0*A)^2 * k with
// 32x32 partial products and divides by A*2^16 one bit a cycle.
// Depends on gced_pkg.
module gced_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                work_valid_i,
  output logic                work_take_o,
  input  gced_pkg::work_t     work_i,
  input  logic [31:0]         gain_i,
  input  logic signed [31:0]  target_i,
  output logic                res_valid_o,
  input  logic                res_take_i,
  output gced_pkg::out_word_t res_o
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_VERT  = 9'b000000010,
    S_TOT   = 9'b000000100,
    S_TERM  = 9'b000001000,
    S_OFFS  = 9'b000010000,
    S_SQ    = 9'b000100000,
    S_GAIN  = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e              state_q, state_d;
  gced_pkg::work_t     wk_q;
  logic signed [47:0]  area_q, curv_q, na_q, nc_q;
  logic [63:0]         energy_q;
  logic [1:0]          pp_q;          // partial-product index
  logic [127:0]        acc_q;         // multiply accumulator
  logic [63:0]         m_q;           // |d|, squared by its low/high halves
  logic [127:0]        sq_q;
  logic [191:0]        w_q;
  logic [64:0]         r_q;
  logic [63:0]         q_q;
  logic [7:0]          bit_q;
  logic                qsat_q;
  logic signed [47:0]  dc_q;
  logic                res_valid_q;
  gced_pkg::out_word_t res_q;

  // Shared 32x32 multiplier operands
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic [32:0] s_mag, da_mag, c0_mag;
  logic [47:0] a_mag;
  assign s_mag  = wk_q.curv_sum[32] ? 33'(-wk_q.curv_sum) : 33'(wk_q.curv_sum);
  assign da_mag = wk_q.delta_area[31] ? 33'(-33'(wk_q.delta_area))
                                      : 33'(wk_q.delta_area);
  assign c0_mag = target_i[31] ? 33'(-33'(target_i)) : 33'(target_i);
  assign a_mag  = na_q; // positive whenever energy is computed

  // Select multiplier operands per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_VERT: begin
        mul_a = pp_q[0] ? {31'd0, s_mag[32]} : s_mag[31:0];
        mul_b = pp_q[1] ? {31'd0, da_mag[32]} : da_mag[31:0];
      end
      S_TERM: begin
        mul_a = pp_q[0] ? {31'd0, c0_mag[32]} : c0_mag[31:0];
        mul_b = pp_q[1] ? {16'd0, a_mag[47:32]} : a_mag[31:0];
      end
      S_SQ: begin
        mul_a = pp_q[0] ? m_q[63:32] : m_q[31:0];
        mul_b = pp_q[1] ? m_q[63:32] : m_q[31:0];
      end
      S_GAIN: begin
        mul_a = gain_i;
        mul_b = sq_q[32*bit_q[1:0] +: 32];
      end
      default: ;
    endcase
  end

  logic [127:0] pp_shift;
  assign pp_shift = (state_q == S_GAIN) ? (128'(mul_p) << (32*bit_q[1:0]))
                  : (128'(mul_p) << (32*({1'b0, pp_q[0]} + {1'b0, pp_q[1]})));

  logic [63:0]  den;
  logic [64:0]  r_sh;
  logic         take;
  logic         fault;
  assign den   = {na_q[47:0], 16'd0};
  assign r_sh  = {r_q[63:0], w_q[191]};
  assign take  = (r_sh >= 65'(den));
  assign fault = (na_q <= 0);
  assign work_take_o = (state_q == S_IDLE) && work_valid_i && !res_valid_q;

  logic [63:0] term_m, d_mag;
  logic signed [64:0] term_s, d_s;
  assign term_m = acc_q[79:16];
  assign term_s = (target_i[31] != na_q[47]) ? -65'(term_m) : 65'(term_m);
  assign d_s    = 65'(nc_q) - term_s;
  assign d_mag  = d_s[64] ? 64'(-d_s) : 64'(d_s);

  // Saturate the quotient; a fault forces zero energy
  logic [63:0] e_new;
  assign e_new = fault ? '0
               : ((qsat_q || q_q[63]) ? 64'h7FFF_FFFF_FFFF_FFFF : q_q);

  // Sequence one work word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      area_q      <= '0;
      curv_q      <= '0;
      energy_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (res_take_i && res_valid_q) res_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (work_take_o) begin
            wk_q  <= work_i;
            pp_q  <= '0;
            acc_q <= '0;
            dc_q  <= 48'(work_i.delta_curvature);
            state_q <= (work_i.req == gced_pkg::REQ_ACCUM) ? S_VERT : S_TOT;
          end
        end
        S_VERT: begin
          acc_q <= acc_q + pp_shift;
          pp_q  <= pp_q + 1'b1;
          if (pp_q == 2'd3) begin
            dc_q <= gced_pkg::sat48(
              (wk_q.curv_sum[32] != wk_q.delta_area[31])
                ? -50'(((acc_q + pp_shift) >> 16))
                : 50'(((acc_q + pp_shift) >> 16)));
            state_q <= S_TOT;
          end
        end
        S_TOT: begin
          na_q  <= gced_pkg::sat48(50'(area_q) + 50'(wk_q.delta_area));
          nc_q  <= gced_pkg::sat48(50'(curv_q) + 50'(dc_q));
          pp_q  <= '0;
          acc_q <= '0;
          state_q <= (wk_q.req == gced_pkg::REQ_NONE) ? S_DONE : S_TERM;
        end
        S_TERM: begin
          if (fault) begin
            state_q <= S_DONE;
          end else begin
            acc_q <= acc_q + pp_shift;
            pp_q  <= pp_q + 1'b1;
            if (pp_q == 2'd3) state_q <= S_OFFS;
          end
        end
        S_OFFS: begin
          m_q   <= d_mag;
          pp_q  <= '0;
          acc_q <= '0;
          state_q <= S_SQ;
        end
        S_SQ: begin
          acc_q <= acc_q + pp_shift;
          pp_q  <= pp_q + 1'b1;
          if (pp_q == 2'd3) begin
            sq_q  <= acc_q + pp_shift;
            w_q   <= '0;
            bit_q <= '0;
            state_q <= S_GAIN;
          end
        end
        S_GAIN: begin
          w_q   <= w_q + (192'(mul_p) << (32*bit_q[1:0]));
          if (bit_q[1:0] == 2'd3) begin
            bit_q  <= 8'd191;
            r_q    <= '0;
            q_q    <= '0;
            qsat_q <= 1'b0;
            state_q <= S_DIV;
          end else begin
            bit_q <= bit_q + 1'b1;
          end
        end
        S_DIV: begin
          w_q <= w_q << 1;
          r_q <= take ? r_sh - 65'(den) : r_sh;
          if (q_q[63:62] != 2'b00) qsat_q <= 1'b1;
          q_q <= {q_q[62:0], take};
          bit_q <= bit_q - 1'b1;
          if (bit_q == 8'd0) state_q <= S_DONE;
        end
        S_DONE: begin
          res_q.area_fault <= fault && (wk_q.req != gced_pkg::REQ_NONE);
          case (wk_q.req)
            gced_pkg::REQ_ACCUM, gced_pkg::REQ_COMMIT: begin
              area_q   <= na_q;
              curv_q   <= nc_q;
              energy_q <= e_new;
              res_q.energy_change <= '0;
              res_q.energy_now    <= e_new;
            end
            gced_pkg::REQ_EVAL: begin
              res_q.energy_change <= fault ? '0 : e_new - energy_q;
              res_q.energy_now    <= energy_q;
            end
            default: begin
              res_q.energy_change <= '0;
              res_q.energy_now    <= energy_q;
            end
          endcase
          res_valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for global_curvature_energy_delta: predicts area,
// curvature and coupling energy for each request word and checks every result.
// Depends on gced_pkg and the block's RTL.
module tb_top;

  localparam longint unsigned CycleLimit = 20000000;
  localparam logic signed [63:0] EnergyMax = 64'sh7FFF_FFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  gced_pkg::in_word_t in_word = '0;
  logic empty;
  logic pop = 1'b0;
  gced_pkg::out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [gced_pkg::CfgIdxW-1:0] cfg_idx = gced_pkg::CfgGain;
  logic [31:0] cfg_data = '0;

  // Predictor state and configuration
  logic signed [47:0] area_tot = '0;
  logic signed [47:0] curv_tot = '0;
  logic signed [63:0] energy_q = '0;
  logic [31:0] gain_q = '0;
  logic signed [31:0] target_q = '0;

  gced_pkg::out_word_t expected_words[$];
  int unsigned errors = 0;
  longint unsigned cycles = 0;
  bit quiet = 1'b0;
  int unsigned stall_left = 0;

  global_curvature_energy_delta u_dut (
    .clk_i(clk), .rst_ni(rst_n), .push(push), .full(full), .in_word_i(in_word),
    .empty(empty), .pop(pop), .out_word_o(out_word),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Check each popped word, then pick the next pop, with random stalls unless quiet
  always @(posedge clk) begin
    gced_pkg::out_word_t want;
    if (rst_n && pop && !empty) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", out_word.energy_now, '0);
      end else begin
        want = expected_words.pop_front();
        if (out_word.energy_change !== want.energy_change)
          report_mismatch("energy_change", out_word.energy_change, want.energy_change);
        if (out_word.energy_now !== want.energy_now)
          report_mismatch("energy_now", out_word.energy_now, want.energy_now);
        if (out_word.area_fault !== want.area_fault)
          report_mismatch("area_fault", 64'(out_word.area_fault),
                          64'(want.area_fault));
      end
    end
    if (quiet) begin
      pop <= 1'b1;
    end else if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 63) == 0) stall_left <= $urandom_range(50, 400);
      else if ($urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 4);
    end
  end

  function automatic logic signed [47:0] clamp48(input logic signed [65:0] v);
    if (v > 66'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
    if (v < -66'sh8000_0000_0000) return 48'sh8000_0000_0000;
    return v[47:0];
  endfunction

  // Coupling energy k*(C - c0*A)^2 / (A*2^16), saturated; area must be positive
  function automatic logic signed [63:0] coupling_energy(input logic signed [47:0] a,
                                                         input logic signed [47:0] c);
    logic [31:0] mc0;
    logic [79:0] prod;
    logic signed [65:0] term;
    logic signed [65:0] offs;
    logic [63:0] moffs;
    logic [191:0] num;
    logic [191:0] den;
    logic [191:0] quot;
    mc0 = target_q[31] ? -target_q : target_q;
    prod = 80'(mc0) * 80'(a[47:0]);
    term = 66'(prod[79:16]);
    if (target_q[31]) term = -term;
    offs = 66'(c);
    offs = offs - term;
    moffs = 64'(offs[65] ? -offs : offs);
    num = 192'(moffs);
    num = num * num;
    num = num * 192'(gain_q);
    den = 192'(a[47:0]);
    den = den << 16;
    quot = num / den;
    if (quot > 192'h7FFF_FFFF_FFFF_FFFF) return EnergyMax;
    return quot[63:0];
  endfunction

  // Advance the predictor by one accepted word and queue its result
  task automatic predict_word(input gced_pkg::in_word_t w);
    gced_pkg::out_word_t res;
    logic signed [32:0] csum;
    logic [32:0] msum;
    logic [31:0] marea;
    logic [64:0] vprod;
    logic signed [65:0] vterm;
    logic signed [65:0] acc;
    logic signed [47:0] dcurv;
    logic signed [47:0] na;
    logic signed [47:0] nc;
    res = '0;
    res.energy_now = energy_q;
    dcurv = 48'(w.delta_curvature);
    case (w.req_type)
      gced_pkg::REQ_ACCUM, gced_pkg::REQ_COMMIT: begin
        if (w.req_type == gced_pkg::REQ_ACCUM) begin
          csum = 33'(w.principal_curv_one);
          csum = csum + 33'(w.principal_curv_two);
          msum = csum[32] ? -csum : csum;
          marea = w.delta_area[31] ? -w.delta_area : w.delta_area;
          vprod = 65'(msum) * 65'(marea);
          vterm = 66'(vprod[64:16]);
          if (csum[32] != w.delta_area[31]) vterm = -vterm;
          dcurv = clamp48(vterm);
        end
        acc = 66'(area_tot);
        area_tot = clamp48(acc + 66'(w.delta_area));
        acc = 66'(curv_tot);
        curv_tot = clamp48(acc + 66'(dcurv));
        if (area_tot <= 0) begin
          res.area_fault = 1'b1;
          energy_q = '0;
        end else begin
          energy_q = coupling_energy(area_tot, curv_tot);
        end
        res.energy_now = energy_q;
      end
      gced_pkg::REQ_EVAL: begin
        acc = 66'(area_tot);
        na = clamp48(acc + 66'(w.delta_area));
        acc = 66'(curv_tot);
        nc = clamp48(acc + 66'(w.delta_curvature));
        if (na <= 0) res.area_fault = 1'b1;
        else res.energy_change = coupling_energy(na, nc) - energy_q;
      end
      default: ;
    endcase
    expected_words.push_back(res);
  endtask

  // Drive one word until accepted, then hold off for a random gap
  task automatic send_word(input gced_pkg::in_word_t w);
    int unsigned gap;
    push <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (full);
    predict_word(w);
    if (quiet) gap = 0;
    else if ($urandom_range(0, 99) < 2) gap = $urandom_range(20, 300);
    else if ($urandom_range(0, 3) == 0) gap = $urandom_range(1, 3);
    else gap = 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_fields(input logic [1:0] req, input logic [31:0] da,
                             input logic [31:0] dc, input logic [31:0] c1,
                             input logic [31:0] c2);
    gced_pkg::in_word_t w;
    w.req_type = req;
    w.delta_area = da;
    w.delta_curvature = dc;
    w.principal_curv_one = c1;
    w.principal_curv_two = c2;
    send_word(w);
  endtask

  // Drain all results, then let the block settle
  task automatic wait_idle;
    push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Write one register while idle
  task automatic write_reg(input logic [gced_pkg::CfgIdxW-1:0] idx,
                           input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx == gced_pkg::CfgGain) gain_q = data;
    else target_q = data;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] gain, input logic [31:0] target);
    wait_idle();
    write_reg(gced_pkg::CfgGain, gain);
    write_reg(gced_pkg::CfgTarget, target);
  endtask

  // Signed value of random width
  function automatic logic [31:0] rand_val;
    logic signed [31:0] v;
    v = $urandom;
    return v >>> $urandom_range(0, 31);
  endfunction

  task automatic test_directed_requests;
    quiet = 1'b1;
    set_config(32'h0001_0000, 32'h0000_8000);
    send_fields(gced_pkg::REQ_EVAL, 32'h0001_0000, 32'h0000_4000, '0, '0);
    send_fields(gced_pkg::REQ_ACCUM, 32'h0002_0000, '0, 32'h0001_0000, 32'h0000_8000);
    send_fields(gced_pkg::REQ_ACCUM, 32'h0000_0001, '1, 32'hFFFF_0000, 32'h0003_0000);
    send_fields(gced_pkg::REQ_EVAL, 32'h0000_8000, 32'h0001_0000, '1, '1);
    send_fields(gced_pkg::REQ_COMMIT, 32'h0000_8000, 32'h0001_0000, '0, '0);
    send_fields(gced_pkg::REQ_NONE, '1, '1, '1, '1);
    send_fields(gced_pkg::REQ_EVAL, 32'hFFF0_0000, '0, '0, '0);
    quiet = 1'b0;
  endtask

  task automatic test_area_fault;
    send_fields(gced_pkg::REQ_COMMIT, -area_tot[31:0], 32'h0000_1000, '0, '0);
    send_fields(gced_pkg::REQ_EVAL, '0, '0, '0, '0);
    send_fields(gced_pkg::REQ_ACCUM, 32'h8000_0000, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_fields(gced_pkg::REQ_NONE, '0, '0, '0, '0);
    send_fields(gced_pkg::REQ_ACCUM, 32'h7FFF_FFFF, '0, 32'h0000_0001, '0);
    send_fields(gced_pkg::REQ_ACCUM, 32'h7FFF_FFFF, '0, 32'h0000_0001, '0);
  endtask

  task automatic test_saturation;
    set_config(32'hFFFF_FFFF, 32'h8000_0000);
    // vertex term pinned at the upper 48-bit limit
    send_fields(gced_pkg::REQ_ACCUM, 32'h8000_0000, '0, 32'h8000_0000, 32'h8000_0000);
    send_fields(gced_pkg::REQ_ACCUM, 32'h7FFF_FFFF, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_fields(gced_pkg::REQ_EVAL, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0);
    send_fields(gced_pkg::REQ_COMMIT, 32'h8000_0001, 32'h7FFF_FFFF, '0, '0);
    send_fields(gced_pkg::REQ_EVAL, 32'h0000_0001, 32'h7FFF_FFFF, '0, '0);
    set_config(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_fields(gced_pkg::REQ_EVAL, 32'h8000_0000, 32'h8000_0000, '0, '0);
    send_fields(gced_pkg::REQ_COMMIT, -area_tot[31:0] + 32'd1, 32'h8000_0000, '0, '0);
    send_fields(gced_pkg::REQ_EVAL, 32'h0000_0010, 32'h7FFF_FFFF, '0, '0);
  endtask

  // Random walk: mostly vertex builds and small moves, plus noise
  task automatic test_random_walk(input int unsigned count);
    int unsigned pick;
    logic [31:0] da;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (n % 97 == 0) quiet = ~quiet;
      if (pick < 30) begin
        send_fields(gced_pkg::REQ_ACCUM, $urandom_range(1, 32'h0010_0000), $urandom,
                    rand_val(), rand_val());
      end else if (pick < 58) begin
        send_fields(gced_pkg::REQ_EVAL, rand_val() >>> 4, rand_val(), $urandom, $urandom);
      end else if (pick < 78) begin
        send_fields(gced_pkg::REQ_COMMIT, rand_val() >>> 6, rand_val(), $urandom,
                    $urandom);
      end else if (pick < 82) begin
        send_fields(gced_pkg::REQ_NONE, $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 93) begin
        send_fields(2'($urandom_range(0, 2)), $urandom, $urandom, $urandom, $urandom);
      end else begin
        // bring the area to around zero
        da = -area_tot[31:0] + $urandom_range(0, 2) - 1;
        send_fields(2'($urandom_range(1, 2)), da, rand_val(), '0, '0);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_requests();
    test_area_fault();
    test_saturation();
    set_config('0, '0);
    test_random_walk(250);
    set_config(32'h0001_0000, 32'h0000_0000);
    test_random_walk(300);
    set_config(32'hFFFF_FFFF, 32'h8000_0000);
    test_random_walk(250);
    set_config($urandom, $urandom);
    test_random_walk(350);
    set_config(32'h0000_0001, 32'h7FFF_FFFF);
    test_random_walk(250);
    set_config($urandom_range(0, 32'h0004_0000), rand_val());
    test_random_walk(400);
    wait_idle();
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
